// ----- rtl/pmst_pkg.sv -----
package pmst_pkg;
    localparam int unsigned MAX_VERTICES_DEF = 16;
    localparam int unsigned WEIGHT_BITS_DEF  = 16;
    localparam int unsigned ADDR_W   = 4;
    localparam int unsigned CNT_W    = 5;
    localparam int unsigned FIELD_W  = 16;

    // Phases of the sequencer.
    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_PICK  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_FETCH = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;
    localparam logic [2:0] ST_EWAIT = 3'd5;

    // Per-cycle commands broadcast to the cells.
    typedef struct packed {
        logic clear;  // restart: key infinity (zero for cell 0), parent zero, out of tree
        logic take;   // the cell whose index matches sel joins the tree
        logic relax;  // the cell whose index matches sel relaxes against weight
    } t_cell_cmd;
endpackage

// ----- rtl/pmst_cell.sv -----
module pmst_cell #(
    parameter int unsigned IDX_W  = 4,
    parameter int unsigned KEY_W  = 17,
    parameter int unsigned WGT_W  = 16,
    parameter int unsigned MY_IDX = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pmst_pkg::t_cell_cmd  i_cmd,
    input  logic [IDX_W-1:0]     i_sel,
    input  logic [IDX_W-1:0]     i_src,
    input  logic [WGT_W-1:0]     i_weight,
    input  logic                 i_active,
    // running minimum handed along the chain
    input  logic                 i_have,
    input  logic [KEY_W-1:0]     i_best_key,
    input  logic [IDX_W-1:0]     i_best_idx,
    output logic                 o_have,
    output logic [KEY_W-1:0]     o_best_key,
    output logic [IDX_W-1:0]     o_best_idx,
    output logic [IDX_W-1:0]     o_parent,
    output logic                 o_lost
);
    import pmst_pkg::*;

    logic [KEY_W-1:0] r_key;
    logic [IDX_W-1:0] r_parent;
    logic             r_in;
    logic             r_have;
    logic [KEY_W-1:0] r_bkey;
    logic [IDX_W-1:0] r_bidx;
    logic             n_have;
    logic [KEY_W-1:0] n_bkey;
    logic [IDX_W-1:0] n_bidx;
    logic             me;
    logic             cand;
    logic [KEY_W-1:0] wext;

    assign me   = (i_sel == IDX_W'(MY_IDX));
    assign wext = KEY_W'(i_weight);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_key    <= (MY_IDX == 0) ? '0 : '1;
            r_parent <= '0;
            r_in     <= 1'b0;
        end else begin
            if (i_cmd.take && me) begin
                r_in <= 1'b1;
            end
            if (i_cmd.relax && me && !r_in && i_weight != '0 && wext < r_key) begin
                r_key    <= wext;
                r_parent <= i_src;
            end
        end
    end

    // Strict compare keeps the lowest index among equal keys; first free cell
    // wins when all keys are infinite.
    assign cand = i_active && !r_in;
    always_comb begin
        n_have = i_have;
        n_bkey = i_best_key;
        n_bidx = i_best_idx;
        if (cand && (!i_have || r_key < i_best_key)) begin
            n_have = 1'b1;
            n_bkey = r_key;
            n_bidx = IDX_W'(MY_IDX);
        end
    end

    // Register the running minimum: it advances one cell per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_bkey <= '1;
            r_bidx <= '0;
        end else begin
            r_have <= n_have;
            r_bkey <= n_bkey;
            r_bidx <= n_bidx;
        end
    end

    assign o_have     = r_have;
    assign o_best_key = r_bkey;
    assign o_best_idx = r_bidx;
    assign o_parent   = r_parent;
    assign o_lost     = (r_key == '1);
endmodule

// ----- rtl/prim_minimum_spanning_tree_top.sv -----
// Prim minimum spanning tree over a loaded adjacency matrix. Send matrix cells
// as requests, one per cycle while o_ready is high (row, column, weight; zero
// weight means no edge). The request flagged last_cell is stored and starts
// the tree from vertex 0 over the first vertex_count vertices. Edges come out
// for children 1 to count-1 in order: parent, child and matrix[child][parent],
// with last_edge on the final one; a child never reached by any edge reports
// unreachable with parent 0 and weight 0. The tree takes (V-1) rounds. Each
// round is a pick, in which the running minimum is registered in every cell
// and advances one cell per cycle along the chain, then a relax scan, in which
// the matrix memory gives one registered weight per cycle to the row of vertex
// cells. Each edge then goes through three steps (fetch its weight, load the
// output register, advance), and the load waits while the receiver stalls.
// Input is held off from the last cell until the final edge sits in the output
// register. The matrix is not cleared at reset; read cells must be written
// first.
module prim_minimum_spanning_tree_top #(
    parameter int unsigned MAX_VERTICES = pmst_pkg::MAX_VERTICES_DEF,
    parameter int unsigned WEIGHT_BITS  = pmst_pkg::WEIGHT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pmst_pkg::CNT_W-1:0]    i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [pmst_pkg::ADDR_W-1:0]   i_cell_row,
    input  logic [pmst_pkg::ADDR_W-1:0]   i_cell_col,
    input  logic [pmst_pkg::FIELD_W-1:0]  i_cell_weight,
    input  logic                          i_last_cell,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [pmst_pkg::ADDR_W-1:0]   o_parent_vertex,
    output logic [pmst_pkg::ADDR_W-1:0]   o_child_vertex,
    output logic [pmst_pkg::FIELD_W-1:0]  o_edge_weight,
    output logic                          o_unreachable,
    output logic                          o_last_edge
);
    import pmst_pkg::*;

    localparam int unsigned IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int unsigned NW = $clog2(MAX_VERTICES + 1);
    localparam int unsigned KW = WEIGHT_BITS + 1;
    localparam int unsigned DEPTH = 1 << (2 * IW);

    logic [CNT_W-1:0]       r_count;
    logic [2:0]             r_state, n_state;
    logic [NW-1:0]          r_n;      // effective vertex count
    logic [NW-1:0]          r_round;  // picks done
    logic [IW-1:0]          r_u;      // vertex just joined
    logic [IW:0]            r_v;      // pick wait / scan / emit index
    logic                   r_ovalid;
    logic [ADDR_W-1:0]      r_opar, r_ochild;
    logic [FIELD_W-1:0]     r_owgt;
    logic                   r_olost, r_olast;
    logic [WEIGHT_BITS-1:0] r_mem [DEPTH];
    logic [WEIGHT_BITS-1:0] r_rd;

    t_cell_cmd              cmd;
    logic [IW-1:0]          sel;
    logic [MAX_VERTICES:0]  hv;
    logic [KW-1:0]          bk [MAX_VERTICES+1];
    logic [IW-1:0]          bi [MAX_VERTICES+1];
    logic [IW-1:0]          par [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] lost;
    logic [NW-1:0]          nclamp;
    logic                   in_ok, out_free;
    logic                   pick_done;
    logic [2*IW-1:0]        rd_addr;
    logic [IW-1:0]          vi;

    // Clamp count into 1..MAX_VERTICES.
    always_comb begin
        if (r_count == '0) begin
            nclamp = NW'(1);
        end else if (32'(r_count) > MAX_VERTICES) begin
            nclamp = NW'(MAX_VERTICES);
        end else begin
            nclamp = NW'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CNT_W'(16);
        end else if (i_cfg_we) begin
            r_count <= i_cfg_wdata;
        end
    end

    assign o_ready  = (r_state == ST_LOAD);
    assign in_ok    = i_valid && o_ready;
    assign out_free = !r_ovalid || i_ready;
    assign vi       = r_v[IW-1:0];
    // The minimum has crossed every cell once the pick has waited this long.
    assign pick_done = (r_state == ST_PICK) && (r_v == (IW+1)'(MAX_VERTICES));

    // Store cells in range; read one weight per cycle.
    always_comb begin
        if (r_state == ST_FETCH || r_state == ST_EMIT || r_state == ST_EWAIT) begin
            rd_addr = {vi, par[vi]};
        end else begin
            rd_addr = {r_u, vi};
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ok && 32'(i_cell_row) < MAX_VERTICES && 32'(i_cell_col) < MAX_VERTICES) begin
            r_mem[{IW'(i_cell_row), IW'(i_cell_col)}] <= WEIGHT_BITS'(i_cell_weight);
        end
        r_rd <= r_mem[rd_addr];
    end

    // Cell commands.
    always_comb begin
        cmd   = '0;
        sel   = r_u;
        cmd.clear = in_ok && i_last_cell;
        if (pick_done) begin
            cmd.take = 1'b1;
            sel      = bi[MAX_VERTICES];
        end
        // r_rd holds weight for index r_v-1 during scan
        if (r_state == ST_SCAN && r_v != '0) begin
            cmd.relax = 1'b1;
            sel       = IW'(r_v - 1'b1);
        end
    end

    assign hv[0] = 1'b0;
    assign bk[0] = '1;
    assign bi[0] = '0;

    genvar g;
    generate
        for (g = 0; g < MAX_VERTICES; g++) begin : g_cell
            pmst_cell #(.IDX_W(IW), .KEY_W(KW), .WGT_W(WEIGHT_BITS), .MY_IDX(g)) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_cmd      (cmd),
                .i_sel      (sel),
                .i_src      (r_u),
                .i_weight   (r_rd),
                .i_active   (NW'(g) < r_n),
                .i_have     (hv[g]),
                .i_best_key (bk[g]),
                .i_best_idx (bi[g]),
                .o_have     (hv[g+1]),
                .o_best_key (bk[g+1]),
                .o_best_idx (bi[g+1]),
                .o_parent   (par[g]),
                .o_lost     (lost[g])
            );
        end
    endgenerate

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD:  if (in_ok && i_last_cell) n_state = (nclamp > NW'(1)) ? ST_PICK : ST_LOAD;
            ST_PICK:  if (pick_done) n_state = ST_SCAN;
            ST_SCAN:  if (r_v == (IW+1)'(r_n)) begin
                          n_state = (r_round == r_n - 1'b1) ? ST_FETCH : ST_PICK;
                      end
            ST_FETCH: n_state = ST_EMIT;
            ST_EMIT:  n_state = out_free ? ST_EWAIT : ST_EMIT;
            ST_EWAIT: n_state = (r_v == (IW+1)'(r_n)) ? ST_LOAD : ST_FETCH;
            default:  n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_ovalid <= 1'b0;
            r_n      <= '0;
            r_round  <= '0;
            r_u      <= '0;
            r_v      <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_EMIT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_LOAD: begin
                    r_n     <= nclamp;
                    r_round <= '0;
                    r_v     <= '0;
                end
                ST_PICK: begin
                    if (pick_done) begin
                        r_u     <= bi[MAX_VERTICES];
                        r_round <= r_round + 1'b1;
                        r_v     <= '0;
                    end else begin
                        r_v     <= r_v + 1'b1;
                    end
                end
                ST_SCAN: begin
                    if (r_v == (IW+1)'(r_n)) begin
                        r_v <= (n_state == ST_FETCH) ? (IW+1)'(1) : '0;
                    end else begin
                        r_v <= r_v + 1'b1;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_opar   <= lost[vi] ? '0 : ADDR_W'(par[vi]);
                        r_ochild <= ADDR_W'(vi);
                        r_owgt   <= lost[vi] ? '0 : FIELD_W'(r_rd);
                        r_olost  <= lost[vi];
                        r_olast  <= (r_v + 1'b1 == (IW+1)'(r_n));
                        r_v      <= r_v + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid         = r_ovalid;
    assign o_parent_vertex = r_opar;
    assign o_child_vertex  = r_ochild;
    assign o_edge_weight   = r_owgt;
    assign o_unreachable   = r_olost;
    assign o_last_edge     = r_olast;
endmodule

// ----- verif/prim_minimum_spanning_tree_top_tb.sv -----
module prim_minimum_spanning_tree_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NV = pmst_pkg::MAX_VERTICES_DEF;
    localparam logic [16:0] KEY_INFINITY = 17'h1FFFF;
    localparam int unsigned STALL_LIMIT = 20000;
    localparam int unsigned DRAIN_CYCLES = 400;

    typedef struct packed {
        logic [3:0]  parent;
        logic [3:0]  child;
        logic [15:0] weight;
        logic        unreachable;
        logic        last_edge;
    } t_tree_edge;

    // Track the matrix and the vertex count; predict the tree on each last cell.
    class mst_scoreboard;
        logic [15:0] matrix [NV][NV];
        int unsigned vertex_count;
        t_tree_edge  pending_edges[$];
        int unsigned error_count;

        function new();
            vertex_count = 16;
            error_count = 0;
            foreach (matrix[r, c]) matrix[r][c] = '0;
        endfunction

        function void note_cell(logic [3:0] row, logic [3:0] col, logic [15:0] w,
                                logic last);
            logic [16:0] key [NV];
            logic [3:0]  parent [NV];
            logic [NV-1:0] joined;
            int unsigned n, best;
            logic [16:0] best_key;
            t_tree_edge e;
            matrix[row][col] = w;
            if (!last) return;
            n = (vertex_count < 1) ? 1 : (vertex_count > NV ? NV : vertex_count);
            for (int i = 0; i < NV; i++) begin
                key[i] = KEY_INFINITY;
                parent[i] = '0;
            end
            joined = '0;
            key[0] = '0;
            for (int i = 0; i + 1 < n; i++) begin
                // Take the lowest key; fall back to the lowest free vertex.
                best = n;
                best_key = KEY_INFINITY;
                for (int v = 0; v < n; v++) begin
                    if (joined[v]) continue;
                    if (best == n) best = v;
                    if (key[v] < best_key) begin
                        best_key = key[v];
                        best = v;
                    end
                end
                if (best >= n) best = 0;
                joined[best] = 1'b1;
                for (int v = 0; v < n; v++) begin
                    if (matrix[best][v] != 0 && !joined[v] &&
                        {1'b0, matrix[best][v]} < key[v]) begin
                        parent[v] = best[3:0];
                        key[v] = {1'b0, matrix[best][v]};
                    end
                end
            end
            for (int v = 1; v < n; v++) begin
                e.unreachable = (key[v] == KEY_INFINITY);
                e.parent = e.unreachable ? 4'd0 : parent[v];
                e.child = v[3:0];
                e.weight = e.unreachable ? 16'd0 : matrix[v][e.parent];
                e.last_edge = (v + 1 == n);
                pending_edges.push_back(e);
            end
        endfunction

        task check_edge(t_tree_edge got);
            t_tree_edge exp_e;
            if (pending_edges.size() == 0) begin
                report_mismatch("edge with nothing pending", 0, got);
                return;
            end
            exp_e = pending_edges.pop_front();
            if (got.parent != exp_e.parent)
                report_mismatch("parent_vertex", exp_e.parent, got.parent);
            if (got.child != exp_e.child)
                report_mismatch("child_vertex", exp_e.child, got.child);
            if (got.weight != exp_e.weight)
                report_mismatch("edge_weight", exp_e.weight, got.weight);
            if (got.unreachable != exp_e.unreachable)
                report_mismatch("unreachable", exp_e.unreachable, got.unreachable);
            if (got.last_edge != exp_e.last_edge)
                report_mismatch("last_edge", exp_e.last_edge, got.last_edge);
        endtask

        task report_mismatch(string what, longint expd, longint got);
            $display("MISMATCH %s: expected %0h got %0h", what, expd, got);
            error_count++;
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [4:0]  i_cfg_wdata = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [3:0]  i_cell_row = '0;
    logic [3:0]  i_cell_col = '0;
    logic [15:0] i_cell_weight = '0;
    logic        i_last_cell = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [3:0]  o_parent_vertex;
    logic [3:0]  o_child_vertex;
    logic [15:0] o_edge_weight;
    logic        o_unreachable;
    logic        o_last_edge;

    mst_scoreboard sb = new();
    bit quiet_phase = 1'b0;   // drop all idling near the end
    bit hold_off = 1'b0;      // receiver stalls for a long stretch
    bit stim_done = 1'b0;
    int unsigned idle_cycles = 0;

    prim_minimum_spanning_tree_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_cell_row(i_cell_row), .i_cell_col(i_cell_col),
        .i_cell_weight(i_cell_weight), .i_last_cell(i_last_cell),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_parent_vertex(o_parent_vertex), .o_child_vertex(o_child_vertex),
        .o_edge_weight(o_edge_weight), .o_unreachable(o_unreachable),
        .o_last_edge(o_last_edge)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Score both channels at the edge from the values that were sampled there.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                sb.note_cell(i_cell_row, i_cell_col, i_cell_weight, i_last_cell);
            if (o_valid && i_ready)
                sb.check_edge({o_parent_vertex, o_child_vertex, o_edge_weight,
                               o_unreachable, o_last_edge});
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: random stall bursts, plus a long hold-off on request.
    initial begin
        int unsigned burst;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off) begin
                i_ready <= 1'b0;
                repeat (600) @(posedge i_clk);
                hold_off = 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
                burst = $urandom_range(1, 13);
                i_ready <= 1'b0;
                repeat (burst) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic send_cell(logic [3:0] row, logic [3:0] col, logic [15:0] w,
                             logic last);
        int unsigned gap;
        if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 13);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cell_row <= row;
        i_cell_col <= col;
        i_cell_weight <= w;
        i_last_cell <= last;
        @(posedge i_clk iff o_ready);
    endtask

    task automatic go_idle();
        i_valid <= 1'b0;
        i_last_cell <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_edges.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_vertex_count(logic [4:0] count);
        go_idle();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= count;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.vertex_count = count;
    endtask

    function automatic logic [15:0] random_weight();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(1, 8));
            default: return 16'($urandom);
        endcase
    endfunction

    // Write every cell inside count, then flag the final one as last.
    task automatic send_graph(int unsigned n, int unsigned mode);
        logic [15:0] w;
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++) begin
                case (mode)
                    0: w = random_weight();
                    1: w = 16'd0;
                    2: w = 16'hFFFF;
                    default: w = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom);
                endcase
                send_cell(r[3:0], c[3:0], w, (r == n - 1) && (c == n - 1));
            end
    endtask

    // Rewrite a few cells of an already written matrix; the final one is last.
    task automatic send_edits(int unsigned n, int unsigned k, bit sparse);
        logic [15:0] w;
        int unsigned r, c;
        for (int i = 0; i < k; i++) begin
            r = $urandom_range(0, n - 1);
            c = $urandom_range(0, n - 1);
            w = sparse ? 16'd0 : random_weight();
            send_cell(r[3:0], c[3:0], w, i == k - 1);
        end
    endtask

    initial begin
        int unsigned n;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: single vertex, no edges, all-max weights, zero count.
        set_vertex_count(5'd1);
        send_cell(4'd0, 4'd0, 16'd7, 1'b1);
        set_vertex_count(5'd0);
        send_cell(4'd0, 4'd0, 16'd0, 1'b1);
        set_vertex_count(5'd3);
        send_graph(3, 1);
        send_graph(3, 2);
        // Cells outside count: stored, ignored; high addresses too.
        send_cell(4'd15, 4'd15, 16'hFFFF, 1'b0);
        send_cell(4'd15, 4'd0, 16'h5A5A, 1'b0);
        send_cell(4'd2, 4'd2, 16'd1, 1'b1);

        // Fill the whole matrix once, then rerun on small rewrites.
        set_vertex_count(5'd16);
        send_graph(16, 0);
        for (int g = 0; g < 8; g++) begin
            if (g == 2) n = 6;
            else n = $urandom_range(2, 16);
            set_vertex_count(n[4:0]);
            if (g == 5) quiet_phase = 1'b1;
            if (g == 2) begin
                // Hold off the receiver while the sender keeps offering cells.
                hold_off = 1'b1;
                send_edits(n, 2, 1'b0);
            end
            send_edits(n, 2, (g % 3) == 1);
        end
        // Counts above the maximum clamp; the matrix is already full.
        set_vertex_count(5'd31);
        send_cell(4'd0, 4'd1, 16'd3, 1'b1);
        set_vertex_count(5'd16);
        send_cell(4'd1, 4'd0, 16'd9, 1'b1);

        go_idle();
        if (sb.error_count == 0 && sb.pending_edges.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/pmst_pkg.sv
rtl/pmst_cell.sv
rtl/prim_minimum_spanning_tree_top.sv
verif/prim_minimum_spanning_tree_top_tb.sv
